/* design/tdsf_pkg.sv */
// Shared types and constants of the timed duplicate signature filter.
package tdsf_pkg;

    localparam int SIG_W  = 16;
    localparam int TICK_W = 32;

    localparam logic [TICK_W-1:0] STALE_AGE_RESET = 32'd30000;

    typedef struct packed {
        logic [SIG_W-1:0]  signature;
        logic [TICK_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic wr;
    } t_tbl_ctl;

endpackage

/* design/tdsf_table.sv */
// Signature table: entry memory with registered read and per-entry active flags.
module tdsf_table #(
    parameter int ENTRIES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tdsf_pkg::t_tbl_ctl           i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]   i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0]   i_clr_addr,
    input  logic [$clog2(ENTRIES)-1:0]   i_wr_addr,
    input  tdsf_pkg::t_entry             i_wr_data,
    output tdsf_pkg::t_entry             o_rd_data,
    output logic                         o_rd_active
);

    tdsf_pkg::t_entry r_mem [ENTRIES];
    tdsf_pkg::t_entry r_rd_data;
    logic [ENTRIES-1:0] r_active;
    logic               r_rd_active;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_rd_active <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_active[i_clr_addr] <= 1'b0;
            end
            if (i_ctl.wr) begin
                r_active[i_wr_addr] <= 1'b1;
            end
            r_rd_active <= r_active[i_rd_addr];
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_rd_active = r_rd_active;

endmodule

/* design/timed_duplicate_signature_filter_unit.sv */
// Top level of the timed duplicate signature filter.
//
// The input channel carries one word per frame: action, signature and the
// current tick count. Each word gets exactly one result word on the output
// channel, with duplicate set when a fresh active table entry holds the same
// signature. The table is scanned from slot 0, one slot per cycle, through
// a memory with a registered read, and the scan stops at the first match
// or at the last slot. A new word is taken only once the previous scan has
// ended. Scanned entries that are stale are cleared; with the record
// action and no match, a new signature is written to the round-robin
// slot when the scan ends. A finished result waits in the output
// register while the next word is accepted; a stalled receiver holds a
// second result until the register frees. The stale age is written through
// the configuration channel, which is always ready and is to be used only
// while the block is idle. Reset clears all entries, the slot pointer and
// the pending result, and sets the stale age to 30000 ticks.
module timed_duplicate_signature_filter_unit #(
    parameter int ENTRIES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic [tdsf_pkg::SIG_W-1:0]  i_signature,
    input  logic [tdsf_pkg::TICK_W-1:0] i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_duplicate,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tdsf_pkg::TICK_W-1:0] i_cfg_stale_age
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_slot;
    logic                          r_action;
    logic [tdsf_pkg::SIG_W-1:0]    r_sig;
    logic [tdsf_pkg::TICK_W-1:0]   r_now;
    logic                          r_dup;
    logic [tdsf_pkg::TICK_W-1:0]   r_stale_age;
    logic                          r_out_valid;
    logic                          r_duplicate;

    tdsf_pkg::t_entry              w_rd_data;
    tdsf_pkg::t_entry              w_wr_data;
    tdsf_pkg::t_tbl_ctl            w_ctl;
    logic                          w_rd_active;
    logic [tdsf_pkg::TICK_W-1:0]   w_age;
    logic                          w_counts;
    logic                          w_match;
    logic                          w_last;
    logic                          w_scan_end;
    logic                          w_record;
    logic                          w_out_free;
    logic [IDX_W-1:0]              n_rd_addr;

    assign w_age      = r_now - w_rd_data.stamp;
    assign w_counts   = w_rd_active && (w_age < r_stale_age);
    assign w_match    = w_counts && (w_rd_data.signature == r_sig);
    assign w_last     = (r_idx == LAST);
    assign w_scan_end = (r_state == S_SCAN) && (w_match || w_last);
    assign w_record   = w_scan_end && !w_match && r_action;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign n_rd_addr = ((r_state == S_SCAN) && !w_last) ? r_idx + 1'b1 : '0;

    assign w_ctl.clr = (r_state == S_SCAN) && !w_counts;
    assign w_ctl.wr  = w_record;
    assign w_wr_data.signature = r_sig;
    assign w_wr_data.stamp     = r_now;

    tdsf_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_rd_addr   (n_rd_addr),
        .i_clr_addr  (r_idx),
        .i_wr_addr   (r_slot),
        .i_wr_data   (w_wr_data),
        .o_rd_data   (w_rd_data),
        .o_rd_active (w_rd_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_slot      <= '0;
            r_stale_age <= tdsf_pkg::STALE_AGE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_stale_age <= i_cfg_stale_age;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= i_action;
                        r_sig    <= i_signature;
                        r_now    <= i_now;
                        r_idx    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        if (w_record) begin
                            r_slot <= (r_slot == LAST) ? '0 : r_slot + 1'b1;
                        end
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_duplicate <= w_match;
                            r_state     <= S_IDLE;
                        end else begin
                            r_dup   <= w_match;
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_duplicate <= r_dup;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_duplicate = r_duplicate;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST))
        else $error("scan index beyond last slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST)
        else $error("round-robin slot out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("accepted word did not start a scan at slot 0");

    a_record_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_record |=> (r_slot != $past(r_slot)))
        else $error("recording did not advance the round-robin slot");
`endif

endmodule
